[src/fnms_pkg.sv]
// Shared constants, types and helpers for the fuzzy name match scorer.
`timescale 1ns / 1ps

package fnms_pkg;

    // Query character slots held by the two 64-bit query registers.
    localparam int QUERY_SLOTS = 16;
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int LEN_REG_W   = 5;
    localparam int SCORE_W     = 12;
    localparam int BONUS_W     = 10;
    localparam int GAP_W       = 5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_LOW    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUERY_HIGH   = 2'd2;

    // Score constants.
    localparam logic [SCORE_W-1:0] SCORE_EXACT  = 12'd2000;
    localparam logic [SCORE_W-1:0] SCORE_PREFIX = 12'd1500;
    localparam logic [SCORE_W-1:0] SCORE_WORD   = 12'd1200;
    localparam logic [SCORE_W-1:0] SCORE_SUB    = 12'd1000;

    // Subsequence bonus constants.
    localparam logic [BONUS_W-1:0] BONUS_START    = 10'd100;
    localparam logic [BONUS_W-1:0] BONUS_ADJACENT = 10'd50;
    localparam logic [GAP_W-1:0]   GAP_SAT        = 5'd31;
    // A gap below this value still earns (29 - gap).
    localparam logic [GAP_W-1:0]   GAP_LIMIT      = 5'd29;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Substring window compare results.
    typedef struct packed {
        logic sub_hit;
        logic word_hit;
    } match_t;

    // ASCII lower-case fold; only 'A'..'Z' change.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[src/fnms_window_match.sv]
// Substring compare of the newest name bytes against the query.
`timescale 1ns / 1ps

module fnms_window_match #(
    parameter int QL = fnms_pkg::QUERY_SLOTS,
    parameter int LW = $clog2(QL + 1),
    parameter int PW = $clog2(QL + 2)
) (
    input  logic [fnms_pkg::CHAR_W-1:0] win   [0:QL],
    input  logic [fnms_pkg::CHAR_W-1:0] query [0:QL-1],
    input  logic [LW-1:0]               len,
    input  logic [PW-1:0]               seen,
    output fnms_pkg::match_t            match
);

    logic                        all_eq;
    logic [fnms_pkg::CHAR_W-1:0] qsel;
    logic [fnms_pkg::CHAR_W-1:0] before_char;
    logic [PW:0]                 seen_x;
    logic [PW:0]                 len_x;

    // Window entry k (newest first) must equal query byte len-1-k.
    always_comb begin
        all_eq = 1'b1;
        for (int k = 0; k < QL; k++) begin
            qsel = '0;
            for (int j = 0; j < QL; j++) begin
                if (int'(len) == j + k + 1) begin
                    qsel = query[j];
                end
            end
            if (k < int'(len) && win[k] != qsel) begin
                all_eq = 1'b0;
            end
        end
    end

    // Byte just ahead of the matched run.
    always_comb begin
        before_char = '0;
        for (int k = 0; k <= QL; k++) begin
            if (int'(len) == k) begin
                before_char = win[k];
            end
        end
    end

    assign seen_x = {1'b0, seen};
    assign len_x  = (PW + 1)'(len);

    assign match.sub_hit  = (len != '0) && (seen_x >= len_x) && all_eq;
    assign match.word_hit = match.sub_hit && (seen_x >= len_x + (PW + 1)'(1))
                            && (before_char == fnms_pkg::CHAR_SPACE);

endmodule

[src/fuzzy_name_match_scorer.sv]
// Top level of the fuzzy name match scorer.
`timescale 1ns / 1ps

// Fuzzy name match scorer.
// A candidate name streams in on the s_ channel, one byte per beat, with
// s_tlast on its final byte. Bytes are folded to ASCII lower case and scored
// against the query held in the configuration registers (length, then the
// low and high eight query bytes). The score of the finished name leaves on
// the m_ channel as one beat; beats without s_tlast give no output.
// The scorer takes one byte per cycle: the window compare, the prefix check
// and the subsequence counters all settle between the input port and the
// state and result registers, so a byte is absorbed in the cycle it is
// accepted. The score appears on m_tvalid in the cycle after the last byte.
// The result register sits between the two channels: s_tready stays high
// while it is empty or being drained, so a stalled receiver holds back input
// only when a score is waiting and not taken. Reset (aresetn low,
// synchronous) clears the query, the per-name state and the output valid.
// Configuration must be written through cfg_we, cfg_addr and cfg_wdata, one
// register per cycle, only while no name is in progress (not enforced).
module fuzzy_name_match_scorer #(
    parameter int MAX_QUERY = fnms_pkg::QUERY_SLOTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [fnms_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fnms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Name byte channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] name_char
    input  logic                              s_tlast,   // last_char
    // Score channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata    // [11:0] score, rest zero
);

    localparam int QL = (MAX_QUERY < fnms_pkg::QUERY_SLOTS) ? MAX_QUERY
                                                            : fnms_pkg::QUERY_SLOTS;
    localparam int LW = $clog2(QL + 1);
    localparam int PW = $clog2(QL + 2);
    localparam logic [PW-1:0] POS_SAT = PW'(QL + 1);

    localparam int CW = fnms_pkg::CHAR_W;
    localparam int SW = fnms_pkg::SCORE_W;
    localparam int BW = fnms_pkg::BONUS_W;
    localparam int GW = fnms_pkg::GAP_W;

    // Configuration state.
    logic [fnms_pkg::LEN_REG_W-1:0] qlen_reg;
    logic [CW-1:0]                  query_reg [0:QL-1];
    logic [LW-1:0]                  len;

    // Per-name state.
    logic [CW-1:0] win_reg  [0:QL];
    logic [CW-1:0] win_next [0:QL];
    logic          prefix_reg,  prefix_next;
    logic [PW-1:0] pos_reg,     pos_next;
    logic          sub_reg,     sub_next;
    logic          word_reg,    word_next;
    logic [LW-1:0] sidx_reg,    sidx_next;
    logic [GW-1:0] gap_reg,     gap_next;
    logic [BW-1:0] bonus_reg,   bonus_next;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [SW-1:0] score_reg;
    logic [SW-1:0] score_next;

    logic              s_acc;
    logic [CW-1:0]     c;
    logic [CW-1:0]     q_pos;
    logic [CW-1:0]     q_sidx;
    logic              hit;
    fnms_pkg::match_t  match;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - SW){1'b0}}, score_reg};

    assign c = fnms_pkg::fold_char(s_tdata);

    // Effective query length, clamped to the slots in use.
    assign len = (qlen_reg > fnms_pkg::LEN_REG_W'(QL)) ? LW'(QL) : qlen_reg[LW-1:0];

    // Configuration writes; query bytes are folded as they are stored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg <= '0;
        end else if (cfg_we && cfg_addr == fnms_pkg::CFG_QUERY_LENGTH) begin
            qlen_reg <= cfg_wdata[fnms_pkg::LEN_REG_W-1:0];
        end
    end

    for (genvar i = 0; i < QL; i++) begin : g_query
        localparam logic [fnms_pkg::CFG_ADDR_W-1:0] SLOT_REG =
            (i < 8) ? fnms_pkg::CFG_QUERY_LOW : fnms_pkg::CFG_QUERY_HIGH;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                query_reg[i] <= '0;
            end else if (cfg_we && cfg_addr == SLOT_REG) begin
                query_reg[i] <= fnms_pkg::fold_char(cfg_wdata[CW*(i % 8) +: CW]);
            end
        end
    end

    // Query bytes at the name position and at the subsequence index.
    always_comb begin
        q_pos  = '0;
        q_sidx = '0;
        for (int i = 0; i < QL; i++) begin
            if (int'(pos_reg) == i) begin
                q_pos = query_reg[i];
            end
            if (int'(sidx_reg) == i) begin
                q_sidx = query_reg[i];
            end
        end
    end

    // Window shifts by one byte, newest at entry zero.
    always_comb begin
        win_next[0] = c;
        for (int k = 1; k <= QL; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    assign pos_next = (pos_reg < POS_SAT) ? pos_reg + PW'(1) : POS_SAT;

    fnms_window_match #(
        .QL (QL),
        .LW (LW),
        .PW (PW)
    ) u_match (
        .win   (win_next),
        .query (query_reg),
        .len   (len),
        .seen  (pos_next),
        .match (match)
    );

    // Prefix, substring flags and the greedy subsequence bonus.
    always_comb begin
        prefix_next = prefix_reg;
        if ((PW + 1)'(pos_reg) < (PW + 1)'(len) && c != q_pos) begin
            prefix_next = 1'b0;
        end
        sub_next  = sub_reg  || match.sub_hit;
        word_next = word_reg || match.word_hit;

        hit        = (sidx_reg < len) && (c == q_sidx);
        sidx_next  = sidx_reg;
        gap_next   = gap_reg;
        bonus_next = bonus_reg;
        if (hit) begin
            if (sidx_reg == '0) begin
                if (pos_reg == '0) begin
                    bonus_next = bonus_reg + fnms_pkg::BONUS_START;
                end
            end else if (gap_reg == '0) begin
                bonus_next = bonus_reg + fnms_pkg::BONUS_ADJACENT;
            end else if (gap_reg < fnms_pkg::GAP_LIMIT) begin
                bonus_next = bonus_reg + BW'(fnms_pkg::GAP_LIMIT - gap_reg);
            end
            sidx_next = sidx_reg + LW'(1);
            gap_next  = '0;
        end else if (gap_reg < fnms_pkg::GAP_SAT) begin
            gap_next = gap_reg + GW'(1);
        end
    end

    // Final score from the state as it stands after this byte.
    always_comb begin
        score_next = '0;
        if (len != '0) begin
            priority if (prefix_next && (PW + 1)'(pos_next) == (PW + 1)'(len)) begin
                score_next = fnms_pkg::SCORE_EXACT;
            end else if (prefix_next && (PW + 1)'(pos_next) >= (PW + 1)'(len)) begin
                score_next = fnms_pkg::SCORE_PREFIX + SW'(len) * SW'(10);
            end else if (word_next) begin
                score_next = fnms_pkg::SCORE_WORD + SW'(len) * SW'(5);
            end else if (sub_next) begin
                score_next = fnms_pkg::SCORE_SUB + SW'(len);
            end else begin
                score_next = '0;
            end
            if (sidx_next == len) begin
                score_next = score_next + SW'(bonus_next);
            end
        end
    end

    assign m_valid_next = (s_acc && s_tlast) || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QL; k++) begin
                win_reg[k] <= '0;
            end
            prefix_reg  <= 1'b1;
            pos_reg     <= '0;
            sub_reg     <= 1'b0;
            word_reg    <= 1'b0;
            sidx_reg    <= '0;
            gap_reg     <= '0;
            bonus_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_acc) begin
                if (s_tlast) begin
                    // Name finished: back to the start-of-name state.
                    for (int k = 0; k <= QL; k++) begin
                        win_reg[k] <= '0;
                    end
                    prefix_reg <= 1'b1;
                    pos_reg    <= '0;
                    sub_reg    <= 1'b0;
                    word_reg   <= 1'b0;
                    sidx_reg   <= '0;
                    gap_reg    <= '0;
                    bonus_reg  <= '0;
                end else begin
                    for (int k = 0; k <= QL; k++) begin
                        win_reg[k] <= win_next[k];
                    end
                    prefix_reg <= prefix_next;
                    pos_reg    <= pos_next;
                    sub_reg    <= sub_next;
                    word_reg   <= word_next;
                    sidx_reg   <= sidx_next;
                    gap_reg    <= gap_next;
                    bonus_reg  <= bonus_next;
                end
            end
        end
    end

    // Score payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_acc && s_tlast) begin
            score_reg <= score_next;
        end
    end

    // A finished name always produces a score beat in the next cycle.
    a_last_gives_score: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> m_tvalid)
        else $error("no score after the last byte of a name");

    // The per-name state starts over after the last byte.
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> pos_reg == '0 && sidx_reg == '0 && bonus_reg == '0
                             && prefix_reg && !sub_reg && !word_reg)
        else $error("name state not cleared after the last byte");

    // Input is held back only while a score waits and is not taken.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the pending score was stalled");

    // A word-boundary substring hit implies a plain substring hit.
    a_word_implies_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        word_reg |-> sub_reg)
        else $error("word substring flag set without substring flag");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the fuzzy name match scorer.
`timescale 1ns / 1ps

// Name bytes are queued by the stimulus process and offered on the s_ channel
// by a clocked driver. Every accepted beat goes through a scoring predictor
// that keeps its own copy of the query and the per-name state. At each byte
// that ends a name, the predictor queues the score it expects. A clocked
// monitor takes scores from the m_ channel and checks each one against the
// oldest expected score. The query is rewritten between phases, and only
// once every expected score has arrived. The query settings cover an empty
// query, a single character, a full sixteen characters and an oversized
// length. Both channels stall at random, except in one phase that runs with
// no idling. In one phase the receiver holds off for a long stretch so that
// the scorer backs up and stalls its input.
module tb_top;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int IDLE_PERCENT  = 19;
    localparam int HOLDOFF_LEN   = 300;
    localparam int PHASE_BYTES   = 95;
    localparam int RANDOM_PHASES = 10;
    localparam int WINDOW        = 17;
    localparam int POS_LIMIT     = 17;
    localparam int GAP_LIMIT     = 31;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Score values of the primary rules and of the subsequence bonus.
    localparam int PTS_EXACT    = 2000;
    localparam int PTS_PREFIX   = 1500;
    localparam int PTS_WORD     = 1200;
    localparam int PTS_SUB      = 1000;
    localparam int PTS_START    = 100;
    localparam int PTS_ADJACENT = 50;
    localparam int PTS_NEAR     = 30;

    typedef enum int {
        RULE_NONE,
        RULE_EXACT,
        RULE_PREFIX,
        RULE_WORD,
        RULE_SUB,
        RULE_COUNT
    } rule_e;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } name_beat_t;

    // DUT ports. Every input is known from time zero.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [fnms_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [fnms_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;   // [7:0] name_char
    logic                            s_tlast   = 1'b0; // last_char
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [15:0]                     m_tdata;          // [11:0] score, rest zero

    // Name bytes waiting for the driver, and scores waiting for the monitor.
    name_beat_t  pending_bytes[$];
    logic [11:0] expected_scores[$];
    logic [7:0]  scratch[$];
    name_beat_t  next_beat;

    // Query as the predictor sees it; q_raw holds the bytes before packing.
    logic [4:0]  q_len  = '0;
    logic [63:0] q_low  = '0;
    logic [63:0] q_high = '0;
    logic [7:0]  q_raw[16];

    // Per-name scoring state of the predictor.
    logic [7:0]  win[WINDOW];
    logic        prefix_match;
    logic [4:0]  name_pos;
    logic        found_sub;
    logic        found_word;
    logic [4:0]  seq_idx;
    logic [4:0]  seq_gap;
    logic [9:0]  seq_bonus;

    // Pacing controls set by the stimulus process.
    logic no_idle       = 1'b0;
    int   holdoff_asked = 0;
    int   holdoff_given = 0;
    int   holdoff_left  = 0;

    int cycles         = 0;
    int mismatches     = 0;
    int bytes_accepted = 0;
    int scores_checked = 0;
    int bonus_names    = 0;
    int query_settings = 0;
    int rule_hits[RULE_COUNT];

    fuzzy_name_match_scorer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scoring predictor
    // ------------------------------------------------------------------

    // Only 'A'..'Z' are folded; every other byte passes as it is.
    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] query_char(input int i);
        logic [63:0] w;
        w = (i >= 8) ? q_high : q_low;
        return lower_case(w[(i % 8) * 8 +: 8]);
    endfunction

    // A length above the sixteen query slots is clipped to sixteen.
    function automatic int used_length();
        return (q_len > 5'd16) ? 16 : int'(q_len);
    endfunction

    task automatic clear_name_state();
        for (int k = 0; k < WINDOW; k++) win[k] = 8'h00;
        prefix_match = 1'b1;
        name_pos     = '0;
        found_sub    = 1'b0;
        found_word   = 1'b0;
        seq_idx      = '0;
        seq_gap      = '0;
        seq_bonus    = '0;
    endtask

    // Folds one accepted name byte into the state; at the end of a name the
    // expected score is queued and the state starts over.
    task automatic absorb_name_byte(input logic [7:0] raw, input logic last);
        logic [7:0] c;
        int         len;
        int         pos;
        int         seen;
        int         span;
        int         score;
        logic       eq;
        rule_e      rule;
        c   = lower_case(raw);
        len = used_length();
        pos = int'(name_pos);

        // win[0] is the newest byte.
        for (int k = WINDOW - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = c;

        if (pos < len && c != query_char(pos)) prefix_match = 1'b0;

        // The whole query must sit in the window, newest byte last.
        seen = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
        if (len > 0 && seen >= len) begin
            eq = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (win[k] != query_char(len - 1 - k)) eq = 1'b0;
            end
            if (eq) begin
                found_sub = 1'b1;
                if (seen >= len + 1 && win[len] == SPACE_CHAR) found_word = 1'b1;
            end
        end

        // Greedy in-order subsequence: the first hit only pays at position
        // zero; later hits pay by their distance from the previous one.
        if (int'(seq_idx) < len && c == query_char(int'(seq_idx))) begin
            if (seq_idx == 0) begin
                if (pos == 0) seq_bonus = seq_bonus + 10'(PTS_START);
            end else begin
                span = int'(seq_gap) + 1;
                if (span == 1) seq_bonus = seq_bonus + 10'(PTS_ADJACENT);
                else if (span < PTS_NEAR) seq_bonus = seq_bonus + 10'(PTS_NEAR - span);
            end
            seq_idx = seq_idx + 5'd1;
            seq_gap = '0;
        end else if (seq_gap < GAP_LIMIT) begin
            seq_gap = seq_gap + 5'd1;
        end
        name_pos = 5'(seen);

        if (last) begin
            score = 0;
            rule  = RULE_NONE;
            if (len > 0) begin
                if (prefix_match && int'(name_pos) == len) begin
                    score = PTS_EXACT;
                    rule  = RULE_EXACT;
                end else if (prefix_match && int'(name_pos) >= len) begin
                    score = PTS_PREFIX + 10 * len;
                    rule  = RULE_PREFIX;
                end else if (found_word) begin
                    score = PTS_WORD + 5 * len;
                    rule  = RULE_WORD;
                end else if (found_sub) begin
                    score = PTS_SUB + len;
                    rule  = RULE_SUB;
                end
                if (int'(seq_idx) == len) begin
                    score = score + int'(seq_bonus);
                    bonus_names++;
                end
            end
            expected_scores.insert(expected_scores.size(), 12'(score));
            rule_hits[rule]++;
            clear_name_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued name bytes and feeds accepted ones to the
    // predictor. A new byte is loaded only when the slot is free or the
    // current one is being taken, so tvalid never drops under a stall.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_name_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
                    next_beat = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.ch;
                    s_tlast  <= next_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each score beat and paces m_tready, including the
    // long hold-off that the stimulus process asks for.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [11:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                scores_checked++;
                if (expected_scores.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected score beat: tdata %h", m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = expected_scores.pop_front();
                    if (m_tdata !== {4'b0000, want}) begin
                        if (mismatches < 10) begin
                            $display("Score mismatch on result %0d: expected %0d, got %0d (tdata %h)",
                                     scores_checked, want, m_tdata[11:0], m_tdata);
                        end
                        mismatches++;
                    end
                end
            end

            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_tready     <= 1'b0;
            end else if (holdoff_given != holdoff_asked) begin
                holdoff_given <= holdoff_given + 1;
                holdoff_left  <= HOLDOFF_LEN;
                m_tready      <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d scores still expected",
                     cycles, expected_scores.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [fnms_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == fnms_pkg::CFG_QUERY_LENGTH) q_len = val[4:0];
        else if (idx == fnms_pkg::CFG_QUERY_LOW) q_low = val;
        else if (idx == fnms_pkg::CFG_QUERY_HIGH) q_high = val;
    endtask

    // Writes all three registers from q_raw; the unused upper bits of the
    // length write carry random values.
    task automatic set_query(input logic [4:0] len);
        logic [63:0] lenword;
        logic [63:0] lo;
        logic [63:0] hi;
        lenword      = {32'($urandom), 32'($urandom)};
        lenword[4:0] = len;
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = q_raw[i];
            hi[i*8 +: 8] = q_raw[i+8];
        end
        write_reg(fnms_pkg::CFG_QUERY_LENGTH, lenword);
        write_reg(fnms_pkg::CFG_QUERY_LOW, lo);
        write_reg(fnms_pkg::CFG_QUERY_HIGH, hi);
        @(posedge aclk);
        cfg_we <= 1'b0;
        query_settings++;
    endtask

    // Returns once nothing is queued, offered or expected.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_scores.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    // Moves the scratch name into the driver queue, marking its last byte.
    task automatic flush_scratch();
        name_beat_t b;
        for (int i = 0; i < scratch.size(); i++) begin
            b.ch   = scratch[i];
            b.last = (i == scratch.size() - 1);
            pending_bytes.insert(pending_bytes.size(), b);
        end
        scratch.delete();
    endtask

    task automatic queue_text(input string txt);
        for (int i = 0; i < txt.len(); i++) scratch.insert(scratch.size(), txt[i]);
        flush_scratch();
    endtask

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        logic is_letter;
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        return (is_letter && $urandom_range(1)) ? (c ^ 8'h20) : c;
    endfunction

    // Query characters drawn mostly from a few letters so that names
    // built around them produce partial and repeated hits.
    function automatic logic [7:0] query_alpha();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'h61 + 8'($urandom_range(7));
        if (r < 85) return 8'h41 + 8'($urandom_range(7));
        if (r < 90) return SPACE_CHAR;
        if (r < 95) return 8'h30 + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] noise_byte(input int len);
        int r;
        r = $urandom_range(99);
        if (len > 0 && r < 50) return vary_case(q_raw[$urandom_range(len - 1)]);
        if (r < 90) return 8'($urandom_range(8'h7E, 8'h20));
        return 8'($urandom_range(255));
    endfunction

    task automatic push_query(input int count);
        for (int i = 0; i < count; i++) scratch.insert(scratch.size(), vary_case(q_raw[i]));
    endtask

    task automatic push_noise(input int count, input int len);
        for (int i = 0; i < count; i++) scratch.insert(scratch.size(), noise_byte(len));
    endtask

    // Builds one candidate name around the current query. Most shapes are
    // well formed (exact, prefix, word start, inner substring, scattered
    // subsequence, long name); the rest are near misses and plain noise.
    task automatic build_name(input int len);
        int gap;
        int cut;
        scratch.delete();
        case ($urandom_range(9))
            0: push_query(len);
            1: begin
                push_query(len);
                push_noise($urandom_range(1, 6), len);
            end
            2: begin
                push_noise($urandom_range(4), len);
                scratch.insert(scratch.size(), SPACE_CHAR);
                push_query(len);
                push_noise($urandom_range(3), len);
            end
            3: begin
                push_noise($urandom_range(1, 5), len);
                push_query(len);
                push_noise($urandom_range(3), len);
            end
            4: begin
                // Scattered hits; some gaps run past the bonus range and
                // past the gap counter's saturation.
                for (int i = 0; i < len; i++) begin
                    gap = ($urandom_range(4) == 0) ? $urandom_range(35) : $urandom_range(3);
                    push_noise(gap, len);
                    scratch.insert(scratch.size(), vary_case(q_raw[i]));
                end
            end
            5: begin
                push_query(len);
                if (len > 0) scratch[$urandom_range(len - 1)] = noise_byte(len);
            end
            6: begin
                for (int i = 0; i < $urandom_range(1, 12); i++) begin
                    scratch.insert(scratch.size(), 8'($urandom_range(255)));
                end
            end
            7: begin
                cut = (len > 0) ? $urandom_range(len - 1) : 0;
                push_query(cut);
                if ($urandom_range(1)) push_noise($urandom_range(1, 3), len);
            end
            8: begin
                // Long name: the position counter can saturate before the end.
                push_noise($urandom_range(10, 30), len);
                push_query(len);
                push_noise($urandom_range(10), len);
            end
            default: push_noise($urandom_range(1, 10), len);
        endcase
        if (scratch.size() == 0) scratch.insert(scratch.size(), noise_byte(len));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int         added;
        int         eff;
        logic [4:0] len;

        clear_name_state();
        for (int i = 0; i < RULE_COUNT; i++) rule_hits[i] = 0;
        for (int i = 0; i < 16; i++) q_raw[i] = 8'h00;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // The reset query is empty, so any name scores zero.
        @(negedge aclk);
        queue_text("A");
        wait_idle();

        // Mixed-case two-character query; the upper bytes are junk that
        // must be ignored.
        for (int i = 0; i < 16; i++) q_raw[i] = 8'($urandom_range(255));
        q_raw[0] = "A";
        q_raw[1] = "b";
        set_query(5'd2);
        @(negedge aclk);
        queue_text("ab");       // exact match after folding
        queue_text("ABz");      // prefix
        queue_text("x ab");     // substring at a word start
        queue_text("xAb");      // substring inside a word
        queue_text("a_b");      // subsequence bonus only
        queue_text("b");        // single byte name, no match
        queue_text("Z@");       // fold boundaries, no match
        scratch.insert(scratch.size(), 8'h00);
        scratch.insert(scratch.size(), 8'hFF);
        flush_scratch();        // extreme byte values
        wait_idle();

        // Random phases, each under its own query setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int i = 0; i < 16; i++) q_raw[i] = 8'($urandom_range(255));
            case (ph)
                0: len = 5'd16;
                1: len = 5'd31;
                2: len = 5'd1;
                3: len = 5'd0;
                default: begin
                    if ($urandom_range(99) < 60) len = 5'($urandom_range(1, 6));
                    else if ($urandom_range(99) < 60) len = 5'($urandom_range(7, 16));
                    else len = 5'($urandom_range(17, 31));
                end
            endcase
            eff = (len > 5'd16) ? 16 : int'(len);
            // Phase 8 keeps fully random query bytes, high values included.
            if (ph != 8) begin
                for (int i = 0; i < eff; i++) q_raw[i] = query_alpha();
            end
            set_query(len);

            @(negedge aclk);
            no_idle = (ph == 5);
            if (ph == 6) holdoff_asked = holdoff_asked + 1;
            added = 0;
            while (added < PHASE_BYTES) begin
                build_name(eff);
                added += scratch.size();
                flush_scratch();
            end
            // The sender pauses here until every score has come back.
            wait_idle();
        end

        repeat (10) @(posedge aclk);

        $display("Checked %0d scores from %0d name bytes under %0d query settings.",
                 scores_checked, bytes_accepted, query_settings);
        $display("Rules hit: exact %0d, prefix %0d, word %0d, substring %0d, none %0d; bonus on %0d.",
                 rule_hits[RULE_EXACT], rule_hits[RULE_PREFIX], rule_hits[RULE_WORD],
                 rule_hits[RULE_SUB], rule_hits[RULE_NONE], bonus_names);
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d scores never arrived",
                     mismatches, expected_scores.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
